// File: hw/rtl/usrs_pkg.sv
// Shared types and constants for the ultrasonic ranging scheduler.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package usrs_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;

  // Item opcodes.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_ECHO = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE_MASK  = 2'd0;
  localparam logic [1:0] REG_SENSOR_MAP   = 2'd1;
  localparam logic [1:0] REG_MIN_INTERVAL = 2'd2;
  localparam logic [1:0] REG_MAX_DIST     = 2'd3;

  localparam logic [3:0]  ENABLE_MASK_RST  = 4'd15;
  localparam logic [7:0]  SENSOR_MAP_RST   = 8'd228;
  localparam logic [19:0] MIN_INTERVAL_RST = 20'd30000;
  localparam logic [12:0] MAX_DIST_RST     = 13'd4500;

  // Divide by 100 as multiply by ceil(2^27/100) and shift; exact for inputs up to
  // 1864134, which covers 17*w+50 for every width below 2^16.
  localparam int          RECIP_SHIFT = 27;
  localparam logic [20:0] RECIP_100   = 21'd1342178;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] sensor;
    logic       echo_level;
  } in_item_t;

  typedef struct packed {
    logic [12:0] read_distance_mm;
    logic        trigger_valid;
    logic [1:0]  trigger_channel;
    logic        update_valid;
  } out_item_t;

  typedef struct packed {
    logic [13:0] dist_mm;
    logic        in_range;
  } conv_res_t;

endpackage

// File: hw/rtl/usrs_echo_conv.sv
// Echo pulse width to millimeters with range check: (w*17+50)/100 < max.
// Depends on usrs_pkg.
`timescale 1ns / 1ps
module usrs_echo_conv import usrs_pkg::*; (
  input  logic [31:0] width_us,
  input  logic [12:0] max_distance_mm,
  output conv_res_t   res
);

  logic [20:0] scaled;
  logic [41:0] prod;
  logic [13:0] conv_mm;

  // Any width of 2^16 us or more lands far beyond the largest limit.
  assign scaled = {1'b0, width_us[15:0], 4'b0000} + {5'b00000, width_us[15:0]} + 21'd50;
  assign prod   = {21'd0, scaled} * {21'd0, RECIP_100};
  assign conv_mm = prod[RECIP_SHIFT+13:RECIP_SHIFT];

  assign res.dist_mm  = conv_mm;
  assign res.in_range = (width_us[31:16] == 16'd0) && (conv_mm < {1'b0, max_distance_mm});

endmodule

// File: hw/rtl/ultrasonic_ranging_scheduler_unit.sv
// An accepted item waits in the input register; its result then loads the result register.
// Throughput: one item per cycle while the output is not stalled; an input register feeds
// one stage of logic that updates the ranging state and loads the result register.
// Reset (synchronous, rst_n low): registers return to defaults, time and distances
// clear to zero, and no item is held.
`timescale 1ns / 1ps
module ultrasonic_ranging_scheduler_unit import usrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic [3:0]  enable_mask_r;
  logic [7:0]  sensor_map_r;
  logic [19:0] min_interval_r;
  logic [12:0] max_dist_r;

  logic [31:0] time_us_r, time_us_nxt;
  logic [31:0] last_trig_r, last_trig_nxt;
  logic [CH_W-1:0] active_ch_r, active_ch_nxt;
  logic [31:0] echo_start_r [CHANNELS];
  logic [12:0] dist_store_r [CHANNELS];

  logic      item_valid_r;
  in_item_t  item_r;
  logic      out_valid_r;
  out_item_t out_r, out_nxt;

  logic advance;
  logic start_wr, dist_wr;
  logic [CH_W-1:0] n_ch, phys_ch, next_ch;
  logic next_found;
  conv_res_t conv;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !item_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign n_ch    = item_r.sensor;
  assign phys_ch = sensor_map_r[2*n_ch +: 2];

  // Round-robin search for the next enabled channel after the active one.
  always_comb begin
    logic [CH_W:0] cand;
    next_ch    = active_ch_r;
    next_found = 1'b0;
    for (int i = CHANNELS; i >= 1; i--) begin
      cand = {1'b0, active_ch_r} + (CH_W+1)'(i);
      if (cand >= (CH_W+1)'(CHANNELS)) begin
        cand = cand - (CH_W+1)'(CHANNELS);
      end
      if (enable_mask_r[cand[CH_W-1:0]]) begin
        next_ch    = cand[CH_W-1:0];
        next_found = 1'b1;
      end
    end
  end

  usrs_echo_conv u_conv (
    .width_us        (time_us_r - echo_start_r[n_ch]),
    .max_distance_mm (max_dist_r),
    .res             (conv)
  );

  always_comb begin
    time_us_nxt   = time_us_r;
    last_trig_nxt = last_trig_r;
    active_ch_nxt = active_ch_r;
    start_wr      = 1'b0;
    dist_wr       = 1'b0;
    out_nxt       = '0;
    case (item_r.op)
      OP_TICK: begin
        time_us_nxt = time_us_r + 32'd1;
      end
      OP_READ: begin
        if (enable_mask_r[n_ch]) begin
          if ((time_us_r - last_trig_r) >= {12'd0, min_interval_r}) begin
            active_ch_nxt = next_ch;
            if (next_found) begin
              out_nxt.trigger_valid   = 1'b1;
              out_nxt.trigger_channel = next_ch;
              last_trig_nxt           = time_us_r;
            end
          end
          out_nxt.read_distance_mm = dist_store_r[phys_ch];
        end
      end
      OP_ECHO: begin
        if (n_ch == active_ch_r && enable_mask_r[n_ch]) begin
          if (item_r.echo_level) begin
            start_wr = 1'b1;
          end else if (conv.in_range) begin
            dist_wr              = 1'b1;
            out_nxt.update_valid = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r  <= ENABLE_MASK_RST;
      sensor_map_r   <= SENSOR_MAP_RST;
      min_interval_r <= MIN_INTERVAL_RST;
      max_dist_r     <= MAX_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE_MASK:  enable_mask_r  <= cfg_data[3:0];
        REG_SENSOR_MAP:   sensor_map_r   <= cfg_data[7:0];
        REG_MIN_INTERVAL: min_interval_r <= cfg_data;
        REG_MAX_DIST:     max_dist_r     <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      time_us_r    <= '0;
      last_trig_r  <= '0;
      active_ch_r  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        echo_start_r[i] <= '0;
        dist_store_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= item_valid_r;
        if (item_valid_r) begin
          time_us_r   <= time_us_nxt;
          last_trig_r <= last_trig_nxt;
          active_ch_r <= active_ch_nxt;
          if (start_wr) begin
            echo_start_r[n_ch] <= time_us_r;
          end
          if (dist_wr) begin
            dist_store_r[n_ch] <= conv.dist_mm[12:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (advance && item_valid_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

// File: hw/rtl/usrs_checker.sv
// Port-level checks for the ultrasonic ranging scheduler, bound to the top level.
// Depends on usrs_pkg.
`timescale 1ns / 1ps
module usrs_checker import usrs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A channel number is shown only with a trigger.
  a_trig_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.trigger_valid |-> out_data.trigger_channel == 2'd0)
    else $error("trigger channel set without trigger");

  // Triggers come from reads, updates from echo items; one item never does both.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.trigger_valid && out_data.update_valid))
    else $error("trigger and update in one item");

  // An echo item that stores a distance returns no read distance.
  a_upd_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.update_valid |-> out_data.read_distance_mm == 13'd0)
    else $error("update item carries a read distance");

  a_after_rst: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind ultrasonic_ranging_scheduler_unit usrs_checker u_usrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/ultrasonic_ranging_scheduler_unit_test.sv
// Self-checking testbench for the ultrasonic ranging scheduler: ticks, reads and echo edges
// are checked against a cycle-free ranging predictor. Depends on usrs_pkg and the unit.
`timescale 1ns / 1ps
module ultrasonic_ranging_scheduler_unit_test;
  import usrs_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [31:0]      now_us;
    logic [31:0]      last_fire_us;
    logic [1:0]       active_ch;
    logic [3:0][31:0] rise_us;
    logic [3:0][12:0] range_mm;
    out_item_t        res;
  } ranging_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_ENABLE_MASK;
  logic [19:0] cfg_data = '0;

  // Register copies; they only change while the unit is idle.
  logic [3:0]  en_mask    = ENABLE_MASK_RST;
  logic [7:0]  chan_map   = SENSOR_MAP_RST;
  logic [19:0] min_gap_us = MIN_INTERVAL_RST;
  logic [12:0] max_mm     = MAX_DIST_RST;

  ranging_state_t planned_state = '0;
  ranging_state_t tracked_state = '0;
  in_item_t       queued_events[$];
  out_item_t      expected_reports[$];
  int             events_sent = 0;
  int             reports_seen = 0;
  int             useful_events = 0;
  int             mismatches = 0;
  int             idle_mode = 0;
  int             send_wait = 0;
  int             recv_wait = 0;

  ultrasonic_ranging_scheduler_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ranging_state_t ranging_step(ranging_state_t st, in_item_t it);
    logic [1:0]  ch;
    logic [1:0]  phys;
    logic        found;
    logic [31:0] elapsed;
    logic [63:0] mm;
    int          k;
    st.res = '0;
    case (it.op)
      OP_TICK: st.now_us = st.now_us + 32'd1;
      OP_READ: begin
        if (en_mask[it.sensor]) begin
          phys = chan_map[2 * it.sensor +: 2];
          elapsed = st.now_us - st.last_fire_us;
          if (elapsed >= {12'd0, min_gap_us}) begin
            // Round-robin to the next enabled channel, wrapping back to the start.
            ch = st.active_ch;
            found = 1'b0;
            for (k = 0; k < CHANNELS; k++) begin
              if (!found) begin
                ch = ch + 2'd1;
                found = en_mask[ch];
              end
            end
            st.active_ch = ch;
            if (found) begin
              st.res.trigger_valid = 1'b1;
              st.res.trigger_channel = ch;
              st.last_fire_us = st.now_us;
            end
          end
          st.res.read_distance_mm = st.range_mm[phys];
        end
      end
      OP_ECHO: begin
        if (it.sensor == st.active_ch && en_mask[it.sensor]) begin
          if (it.echo_level) begin
            st.rise_us[it.sensor] = st.now_us;
          end else begin
            elapsed = st.now_us - st.rise_us[it.sensor];
            mm = ({32'd0, elapsed} * 64'd17 + 64'd50) / 64'd100;
            if (mm < {51'd0, max_mm}) begin
              st.range_mm[it.sensor] = mm[12:0];
              st.res.update_valid = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return st;
  endfunction

  function automatic int idle_draw();
    case (idle_mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Input side: presents queued items; the expected report is worked out at acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
      tracked_state = '0;
    end else begin
      if (in_valid && in_ready) begin
        tracked_state = ranging_step(tracked_state, in_data);
        expected_reports.push_back(tracked_state.res);
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          in_valid <= 1'b0;
          send_wait--;
        end else if (queued_events.size() > 0) begin
          in_data <= queued_events.pop_front();
          in_valid <= 1'b1;
          send_wait = idle_draw();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string field, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stalls on out_ready, in-order compare against the oldest report.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result %h arrived with nothing expected", $time, out_data);
          mismatches++;
        end else begin
          compare_field("read_distance_mm", expected_reports[0].read_distance_mm,
                        out_data.read_distance_mm);
          compare_field("trigger_valid", expected_reports[0].trigger_valid,
                        out_data.trigger_valid);
          compare_field("trigger_channel", expected_reports[0].trigger_channel,
                        out_data.trigger_channel);
          compare_field("update_valid", expected_reports[0].update_valid,
                        out_data.update_valid);
          void'(expected_reports.pop_front());
        end
        reports_seen++;
        recv_wait = idle_draw();
      end
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic issue(logic [1:0] op, logic [1:0] sensor, logic lvl);
    in_item_t it;
    it.op = op;
    it.sensor = sensor;
    it.echo_level = lvl;
    if (op != OP_NONE &&
        !(op == OP_ECHO && !(sensor == planned_state.active_ch && en_mask[sensor])))
      useful_events++;
    planned_state = ranging_step(planned_state, it);
    queued_events.push_back(it);
    events_sent++;
  endtask

  task automatic run_ticks(int n);
    repeat (n) issue(OP_TICK, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE_MASK:  en_mask = val[3:0];
      REG_SENSOR_MAP:   chan_map = val[7:0];
      REG_MIN_INTERVAL: min_gap_us = val;
      REG_MAX_DIST:     max_mm = val[12:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [3:0] en, logic [7:0] map, logic [19:0] gap, logic [12:0] mx);
    write_reg(REG_ENABLE_MASK, {16'd0, en});
    write_reg(REG_SENSOR_MAP, {12'd0, map});
    write_reg(REG_MIN_INTERVAL, gap);
    write_reg(REG_MAX_DIST, {7'd0, mx});
  endtask

  // Every item gives exactly one result, so idle means all results are back.
  task automatic drain();
    wait (reports_seen == events_sent);
    repeat (4) @(posedge clk);
  endtask

  task automatic ranging_phase(int goal);
    logic [1:0] s;
    logic [1:0] ch;
    logic [1:0] other;
    int         k;
    int         w;
    useful_events = 0;
    while (useful_events < goal) begin
      case ($urandom_range(0, 9))
        0, 1: issue(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)));
        2: begin
          // Malformed echo: double rise, edge on another channel, fall without a new rise.
          ch = planned_state.active_ch;
          other = ch + 2'($urandom_range(1, 3));
          issue(OP_ECHO, ch, 1'b1);
          run_ticks($urandom_range(0, 5));
          issue(OP_ECHO, ch, 1'b1);
          run_ticks($urandom_range(0, 5));
          issue(OP_ECHO, other, 1'($urandom_range(0, 1)));
          issue(OP_ECHO, ch, 1'b0);
        end
        default: begin
          run_ticks($urandom_range(0, 8));
          s = 2'($urandom_range(0, 3));
          for (k = 0; k < 4; k++)
            if (!en_mask[s]) s = 2'($urandom_range(0, 3));
          issue(OP_READ, s, 1'($urandom_range(0, 1)));
          ch = planned_state.active_ch;
          issue(OP_ECHO, ch, 1'b1);
          w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
          run_ticks(w);
          issue(OP_ECHO, ch, 1'b0);
          if ($urandom_range(0, 3) == 0) begin
            run_ticks($urandom_range(0, 3));
            issue(OP_ECHO, ch, 1'b0);
          end
          s = 2'($urandom_range(0, 3));
          for (k = 0; k < 4; k++)
            if (chan_map[2 * k +: 2] == ch) s = 2'(k);
          issue(OP_READ, s, 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [3:0]  en;
    logic [7:0]  map;
    logic [19:0] gap;
    logic [12:0] mx;
    int          p;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the long interval blocks triggers, channel 0 is active.
    idle_mode = 0;
    for (p = 0; p < 4; p++) issue(OP_READ, 2'(p), 1'b0);
    issue(OP_NONE, 2'd3, 1'b1);
    issue(OP_ECHO, 2'd0, 1'b1);
    run_ticks(3);
    issue(OP_ECHO, 2'd0, 1'b0);
    issue(OP_ECHO, 2'd0, 1'b0);
    issue(OP_ECHO, 2'd1, 1'b1);
    issue(OP_READ, 2'd0, 1'b0);
    drain();

    // Sensor 0 disabled, reversed map, zero interval, tiny distance limit.
    configure(4'b1110, 8'd27, 20'd0, 13'd2);
    idle_mode = 2;
    issue(OP_READ, 2'd0, 1'b0);
    issue(OP_READ, 2'd1, 1'b0);
    issue(OP_ECHO, 2'd0, 1'b1);
    issue(OP_ECHO, 2'd1, 1'b1);
    run_ticks(5);
    issue(OP_ECHO, 2'd1, 1'b0);
    run_ticks(7);
    issue(OP_ECHO, 2'd1, 1'b0);
    issue(OP_READ, 2'd2, 1'b1);
    drain();

    // Longest pulse that still fits below a 68 mm limit, then one tick past it.
    configure(4'hF, SENSOR_MAP_RST, 20'd0, 13'd68);
    idle_mode = 0;
    issue(OP_READ, 2'd3, 1'b0);
    issue(OP_ECHO, planned_state.active_ch, 1'b1);
    run_ticks(397);
    issue(OP_ECHO, planned_state.active_ch, 1'b0);
    run_ticks(1);
    issue(OP_ECHO, planned_state.active_ch, 1'b0);
    issue(OP_READ, 2'd3, 1'b0);
    drain();

    for (p = 0; p < 12; p++) begin
      en  = (p == 0) ? 4'hF : (p == 1) ? 4'h0 : 4'($urandom_range(0, 15));
      map = (p == 2) ? 8'd0 : (p == 3) ? 8'd255 : 8'($urandom_range(0, 255));
      if (p == 4)
        gap = 20'd1000000;
      else if (p == 5)
        gap = 20'd0;
      else
        gap = ($urandom_range(0, 5) == 0) ? 20'($urandom_range(0, 1000000))
                                         : 20'($urandom_range(0, 30));
      if (p == 6)
        mx = 13'd1;
      else if (p == 7)
        mx = 13'd8191;
      else
        mx = $urandom_range(0, 1) ? 13'($urandom_range(1, 12)) : 13'($urandom_range(1, 8191));
      configure(en, map, gap, mx);
      idle_mode = p % 3;
      ranging_phase(50);
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/usrs_pkg.sv
hw/rtl/usrs_echo_conv.sv
hw/rtl/ultrasonic_ranging_scheduler_unit.sv
hw/rtl/usrs_checker.sv
tb/ultrasonic_ranging_scheduler_unit_test.sv
